// ===== design/tlb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_pkg
// Shared codes and controller/datapath interface types for the LRU TLB.
// ----------------------------------------------------------------------------
package tlb_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned STAMP_W = 64;

  // command codes
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FLUSHED  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic       capture;     // latch the incoming transaction
    logic       stamp_hit;   // restamp the hit entry, bump counter
    logic       ins_free;    // insert into first invalid entry
    logic       ins_victim;  // insert into the LRU victim
    logic       flush;       // drop all entries, clear counter
    logic       scan_step;   // advance the stamp read pointer
    logic       scan_cmp;    // compare returned stamp against running min
    logic       res_load;    // load result registers
    logic       res_hit;     // result carries the frame read data
    logic [1:0] res_status;
  } tlb_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       hit;
    logic       all_valid;
    logic       scan_last;
  } tlb_sts_t;

endpackage
`default_nettype wire

// ===== design/tlb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/tlb_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_datapath
// Tag lanes, valid bits, frame and stamp RAMs, use counter, LRU scan and
// result registers.
// ----------------------------------------------------------------------------
module tlb_datapath #(
  parameter int unsigned TLB_ENTRIES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tlb_pkg::tlb_ctl_t           ctl,
  output tlb_pkg::tlb_sts_t                sts,
  input  wire logic [1:0]                  command,
  input  wire logic [tlb_pkg::ADDR_W-1:0]  virtual_address,
  input  wire logic [tlb_pkg::ADDR_W-1:0]  physical_address,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [tlb_pkg::ADDR_W-1:0]       translated_address
);

  localparam int unsigned IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

  logic [1:0]                   cmd_q;
  logic [tlb_pkg::ADDR_W-1:0]   va_q;
  logic [tlb_pkg::ADDR_W-1:0]   pa_q;
  logic [TLB_ENTRIES-1:0]       valid;
  logic [tlb_pkg::ADDR_W-1:0]   tag [TLB_ENTRIES];
  logic [tlb_pkg::STAMP_W-1:0]  use_counter;
  logic [IDX_W-1:0]             scan_addr;
  logic [IDX_W-1:0]             data_idx;
  logic [tlb_pkg::STAMP_W-1:0]  min_stamp;
  logic [IDX_W-1:0]             victim;

  logic [TLB_ENTRIES-1:0]       match;
  logic                         hit;
  logic [IDX_W-1:0]             hit_idx;
  logic [IDX_W-1:0]             free_idx;
  logic [IDX_W-1:0]             slot;
  logic                         ins;
  logic                         stamp_we;
  logic [IDX_W-1:0]             stamp_waddr;
  logic [tlb_pkg::ADDR_W-1:0]   frame_rd;
  logic [tlb_pkg::STAMP_W-1:0]  stamp_rd;

  // parallel tag compare, lowest index wins
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid[i] && (tag[i] == va_q);
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    hit = |match;
  end

  assign ins         = ctl.ins_free | ctl.ins_victim;
  assign slot        = ctl.ins_free ? free_idx : victim;
  assign stamp_we    = ctl.stamp_hit | ins;
  assign stamp_waddr = ctl.stamp_hit ? hit_idx : slot;

  assign sts.cmd       = cmd_q;
  assign sts.hit       = hit;
  assign sts.all_valid = &valid;
  assign sts.scan_last = (data_idx == LAST_IDX);

  tlb_ram #(.WIDTH(tlb_pkg::ADDR_W), .DEPTH(TLB_ENTRIES)) u_frame_ram (
    .clk   (clk),
    .we    (ins),
    .waddr (slot),
    .wdata (pa_q),
    .raddr (hit_idx),
    .rdata (frame_rd)
  );

  tlb_ram #(.WIDTH(tlb_pkg::STAMP_W), .DEPTH(TLB_ENTRIES)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (use_counter),
    .raddr (scan_addr),
    .rdata (stamp_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      use_counter <= '0;
      done        <= 1'b0;
    end else begin
      done <= ctl.res_load;
      if (ctl.flush) begin
        valid       <= '0;
        use_counter <= '0;
      end else begin
        if (ins) begin
          valid[slot] <= 1'b1;
        end
        if (stamp_we) begin
          use_counter <= use_counter + 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= command;
      va_q  <= virtual_address;
      pa_q  <= physical_address;
    end
    if (ins) begin
      tag[slot] <= va_q;
    end
    if (ctl.capture) begin
      scan_addr <= '0;
    end else if (ctl.scan_step && (scan_addr != LAST_IDX)) begin
      scan_addr <= scan_addr + 1'b1;
    end
    data_idx <= scan_addr;
    if (ctl.scan_cmp && ((data_idx == '0) || (stamp_rd < min_stamp))) begin
      min_stamp <= stamp_rd;
      victim    <= data_idx;
    end
    if (ctl.res_load) begin
      status             <= ctl.res_status;
      translated_address <= ctl.res_hit ? frame_rd : '0;
    end
  end

endmodule
`default_nettype wire

// ===== design/tlb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_ctrl
// Sequencer: decode, hit readout, LRU victim scan and replace.
// ----------------------------------------------------------------------------
module tlb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire tlb_pkg::tlb_sts_t sts,
  output tlb_pkg::tlb_ctl_t      ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HIT_OUT,
    S_SCAN,
    S_REPLACE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (sts.cmd)
          tlb_pkg::CMD_LOOKUP: begin
            if (sts.hit) begin
              ctl.stamp_hit = 1'b1;
              state_next    = S_HIT_OUT;
            end else begin
              ctl.res_load   = 1'b1;
              ctl.res_status = tlb_pkg::ST_MISS;
            end
          end
          tlb_pkg::CMD_INSERT: begin
            if (sts.all_valid) begin
              ctl.scan_step = 1'b1;
              state_next    = S_SCAN;
            end else begin
              ctl.ins_free   = 1'b1;
              ctl.res_load   = 1'b1;
              ctl.res_status = tlb_pkg::ST_INSERTED;
            end
          end
          tlb_pkg::CMD_FLUSH: begin
            ctl.flush      = 1'b1;
            ctl.res_load   = 1'b1;
            ctl.res_status = tlb_pkg::ST_FLUSHED;
          end
          default: begin
            ctl.res_load   = 1'b1;
            ctl.res_status = tlb_pkg::ST_MISS;
          end
        endcase
      end
      S_HIT_OUT: begin
        ctl.res_load   = 1'b1;
        ctl.res_hit    = 1'b1;
        ctl.res_status = tlb_pkg::ST_HIT;
        state_next     = S_IDLE;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        ctl.scan_cmp  = 1'b1;
        if (sts.scan_last) begin
          state_next = S_REPLACE;
        end
      end
      S_REPLACE: begin
        ctl.ins_victim = 1'b1;
        ctl.res_load   = 1'b1;
        ctl.res_status = tlb_pkg::ST_INSERTED;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule
`default_nettype wire

// ===== design/tlb_lru_lookup_insert_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_lru_lookup_insert_top
// Fully associative TLB, full 32-bit VA tag, LRU replacement by use stamps.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   --------------------------------------------
//  request   start & !busy        command, virtual_address, physical_address
//  result    done (1-cycle strb)  status, translated_address
//
//  States per transaction (accept to next accept possible):
//    miss, flush, unused command, insert with a free entry : DECODE
//    lookup hit (frame RAM read, registered) : DECODE, HIT_OUT
//    insert with every entry valid : DECODE, SCAN, REPLACE
//  The LRU victim scan for a full-buffer insert reads one 64-bit stamp per
//  cycle through the stamp RAM read port.
//  Reset is synchronous; it drops all valid bits and the use counter at once.
//  The result is shown the cycle after the deciding step, exactly one cycle;
//  the receiver cannot stall, and a new transaction may be accepted in that
//  same cycle.
//
module tlb_lru_lookup_insert_top #(
  parameter int unsigned TLB_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request transaction
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] virtual_address,
  input  wire logic [31:0] physical_address,
  // result transaction
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      translated_address
);

  // command / status between sequencer and datapath
  tlb_pkg::tlb_ctl_t ctl;
  tlb_pkg::tlb_sts_t sts;

  tlb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // tag lanes, valid bits, frame/stamp RAMs, counter, scan, result registers
  tlb_datapath #(.TLB_ENTRIES(TLB_ENTRIES)) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .sts                (sts),
    .command            (command),
    .virtual_address    (virtual_address),
    .physical_address   (physical_address),
    .done               (done),
    .status             (status),
    .translated_address (translated_address)
  );

endmodule
`default_nettype wire
